// File: src/iplpm_pkg.sv
// Package for the IPv4 longest-prefix-match table unit.
// Holds transfer payload types, the route entry type and the prefix mask helper.
// No dependencies.
package iplpm_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 64;
  localparam int ADDR_W = 32;
  localparam int LEN_W = 6;
  localparam int PORT_W = 8;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic mode;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0] prefix_len;
    logic [PORT_W-1:0] port;
  } in_item_t;

  typedef struct packed {
    logic found;
    logic [PORT_W-1:0] out_port;
    logic [LEN_W-1:0] matched_len;
    logic status;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0] length;
    logic [PORT_W-1:0] port;
  } route_t;

  // len is at most 32 here
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] ones;
    ones = '1;
    return ~(ones >> len);
  endfunction

endpackage

// File: src/ip_longest_prefix_match_table_unit.sv
// Top level of the IPv4 longest-prefix-match table unit.
// Route table in one synchronous memory, scanned one entry per cycle.
// Depends on iplpm_pkg.
//
// Usage:
//   in_valid/in_stall/in_data carry one item per transfer: a lookup (mode 0)
//   or a route insert (mode 1). out_valid/out_stall/out_data return exactly
//   one result per item, in order.
//   Each item reads every stored route once through the memory's single read
//   port, one entry per cycle. The result is loaded after the scan; the next
//   item can transfer in the cycle after its result is loaded.
//   One item is worked on at a time; in_stall is high while an item is in
//   the scan or its result waits to be loaded into the output register.
//   The output register holds a result while out_stall is high; a finished
//   item then waits until that register frees, and the input stays stalled.
//   An insert writes its entry when its result is loaded.
//   Reset empties the table (route count to zero) and drops any result;
//   no clearing pass is needed, entries at or beyond the count are never read.
//   A full table refuses new routes with status 1; a duplicate route
//   (same masked address and length) overwrites its port even when full.
module ip_longest_prefix_match_table_unit #(
  parameter int TABLE_DEPTH = iplpm_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  iplpm_pkg::in_item_t in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output iplpm_pkg::out_item_t out_data
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  iplpm_pkg::route_t mem [TABLE_DEPTH];
  iplpm_pkg::route_t rd_data_r;
  logic              rd_en;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  iplpm_pkg::route_t wr_data;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0] cmp_idx_r;
  logic             cmp_vld_r, cmp_vld_nxt;

  logic                            mode_r;
  logic [iplpm_pkg::ADDR_W-1:0]    addr_r;
  logic [iplpm_pkg::LEN_W-1:0]     len_r;
  logic [iplpm_pkg::PORT_W-1:0]    port_r;

  logic                            best_found_r, best_found_nxt;
  logic [iplpm_pkg::LEN_W-1:0]     best_len_r, best_len_nxt;
  logic [iplpm_pkg::PORT_W-1:0]    best_port_r, best_port_nxt;
  logic [IDX_W-1:0]                hit_idx_r, hit_idx_nxt;

  logic                 out_valid_r, out_valid_nxt;
  iplpm_pkg::out_item_t out_data_r, out_data_nxt;

  logic                            in_xfer;
  logic                            out_free;
  logic [iplpm_pkg::LEN_W-1:0]     in_len;
  logic                            ent_match;

  assign in_xfer  = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign in_len   = (in_data.prefix_len > iplpm_pkg::MAX_LEN) ? iplpm_pkg::MAX_LEN
                                                              : in_data.prefix_len;

  always_comb begin
    if (mode_r == iplpm_pkg::MODE_LOOKUP) begin
      ent_match = (addr_r & iplpm_pkg::prefix_mask(rd_data_r.length)) == rd_data_r.address;
    end else begin
      ent_match = (rd_data_r.length == len_r) && (rd_data_r.address == addr_r);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rd_idx_nxt     = rd_idx_r;
    cmp_vld_nxt    = 1'b0;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    wr_idx         = hit_idx_r;
    wr_data        = '{address: addr_r, length: len_r, port: port_r};
    best_found_nxt = best_found_r;
    best_len_nxt   = best_len_r;
    best_port_nxt  = best_port_r;
    hit_idx_nxt    = hit_idx_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;

    if (cmp_vld_r && ent_match) begin
      if (mode_r == iplpm_pkg::MODE_LOOKUP) begin
        if (!best_found_r || rd_data_r.length > best_len_r) begin
          best_found_nxt = 1'b1;
          best_len_nxt   = rd_data_r.length;
          best_port_nxt  = rd_data_r.port;
        end
      end else if (!best_found_r) begin
        best_found_nxt = 1'b1;
        hit_idx_nxt    = cmp_idx_r;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          rd_idx_nxt     = '0;
          best_found_nxt = 1'b0;
          best_len_nxt   = '0;
          best_port_nxt  = '0;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_idx_r < count_r) begin
          rd_en       = 1'b1;
          cmp_vld_nxt = 1'b1;
          rd_idx_nxt  = rd_idx_r + 1'b1;
        end else if (!cmp_vld_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          if (mode_r == iplpm_pkg::MODE_LOOKUP) begin
            out_data_nxt.found       = best_found_r;
            out_data_nxt.out_port    = best_port_r;
            out_data_nxt.matched_len = best_len_r;
            out_data_nxt.status      = iplpm_pkg::STATUS_OK;
          end else if (best_found_r) begin
            wr_en  = 1'b1;
            wr_idx = hit_idx_r;
            out_data_nxt.status = iplpm_pkg::STATUS_OK;
          end else if (count_r != FULL_CNT) begin
            wr_en     = 1'b1;
            wr_idx    = count_r[IDX_W-1:0];
            count_nxt = count_r + 1'b1;
            out_data_nxt.status = iplpm_pkg::STATUS_OK;
          end else begin
            out_data_nxt.status = iplpm_pkg::STATUS_FULL;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // route memory, one read and one write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r     <= rd_idx_nxt;
    cmp_idx_r    <= rd_idx_r[IDX_W-1:0];
    best_found_r <= best_found_nxt;
    best_len_r   <= best_len_nxt;
    best_port_r  <= best_port_nxt;
    hit_idx_r    <= hit_idx_nxt;
    out_data_r   <= out_data_nxt;
    if (in_xfer) begin
      mode_r <= in_data.mode;
      len_r  <= in_len;
      port_r <= in_data.port;
      if (in_data.mode == iplpm_pkg::MODE_INSERT) begin
        addr_r <= in_data.address & iplpm_pkg::prefix_mask(in_len);
      end else begin
        addr_r <= in_data.address;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
